// ===== design/pofc_pkg.sv =====
// Package for the pulse oximeter filter chain: widths, reset constants, helpers.
// No dependencies.
package pofc_pkg;

	localparam int MEAN_TAPS_DEF = 15;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LP_IN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LP_FB     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 2'd3;

	localparam logic [15:0] DC_ALPHA_RST = 16'd62259;
	localparam logic [15:0] LP_IN_RST    = 16'd16072;
	localparam logic [15:0] LP_FB_RST    = 16'd33392;
	localparam logic [9:0]  WIN_LEN_RST  = 10'd500;

	// lane sequencer states
	typedef enum logic [3:0] {
		ST_IDLE, ST_DC_MUL, ST_DC_SUB, ST_MEAN, ST_TOT, ST_DIV_GO, ST_DIV, ST_DIFF,
		ST_LP_MUL_A, ST_LP_MUL_B, ST_LP_SUM, ST_OUT, ST_SQ, ST_DONE
	} lane_state_t;

	// control from the top to each lane
	typedef struct packed {
		logic       start;
		logic [6:0] fill;
		logic [5:0] pos;
		logic       clear_sq;
	} lane_ctl_t;

	function automatic logic signed [35:0] sat36(input logic signed [63:0] v);
		if (v > 64'sd34359738367) return 36'sh7FFFFFFFF;
		else if (v < -64'sd34359738368) return 36'sh800000000;
		else return v[35:0];
	endfunction

	function automatic logic signed [26:0] sat27(input logic signed [63:0] v);
		if (v > 64'sd67108863) return 27'sh3FFFFFF;
		else if (v < -64'sd67108864) return 27'sh4000000;
		else return v[26:0];
	endfunction

endpackage

// ===== design/pulse_oximeter_filter_chain_top.sv =====
// Top level of the two-channel pulse oximeter filter chain.
// Depends on pofc_pkg and pofc_lane.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | ir_sample, red_sample
//  out     | out_valid/out_ready| ir_filtered, red_filtered, window_done, sums
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// An item is accepted only while no other is in flight; the serial mean
// divider in each lane takes one quotient bit per cycle over the
// 41-bit mean total. in_ready returns as the result is posted on out_valid,
// so a new item is taken only after the last; a result held by out_ready holds the input.
// The two lanes run in parallel; the merge stage holds the result register.
// Reset clears all filter state, the ring and the registers to their defaults.
module pulse_oximeter_filter_chain_top import pofc_pkg::*; #(
	parameter int MEAN_TAPS = MEAN_TAPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           ir_sample,
	input  logic [15:0]           red_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [26:0]    ir_filtered,
	output logic signed [26:0]    red_filtered,
	output logic                  window_done,
	output logic [47:0]           ir_square_sum,
	output logic [47:0]           red_square_sum,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic [15:0] alpha_q, lpin_q, lpfb_q;
	logic [9:0]  winlen_q, wcnt_q;
	logic [5:0]  pos_q;
	logic [6:0]  fill_q, fill_n;
	logic [15:0] ir_q, red_q;
	logic        busy_q;
	logic        ir_done, red_done;
	logic signed [26:0] ir_y, red_y;
	logic [47:0] ir_sq, red_sq;
	logic        close;
	lane_ctl_t   ctl;

	assign fill_n   = (fill_q < 7'(MEAN_TAPS)) ? fill_q + 7'd1 : 7'(MEAN_TAPS);
	assign close    = 11'(wcnt_q) + 11'd1 >= 11'(winlen_q);
	assign in_ready = !busy_q && (!out_valid || out_ready);

	// start is raised the cycle after acceptance so the sample register is loaded
	logic start_q;
	assign ctl = '{start: start_q, fill: fill_n, pos: pos_q, clear_sq: close};

	pofc_lane #(.MEAN_TAPS(MEAN_TAPS)) u_ir (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(ir_q), .dc_alpha(alpha_q),
		.lp_in(lpin_q), .lp_fb(lpfb_q), .done(ir_done), .filtered(ir_y), .square_sum(ir_sq)
	);
	pofc_lane #(.MEAN_TAPS(MEAN_TAPS)) u_red (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(red_q), .dc_alpha(alpha_q),
		.lp_in(lpin_q), .lp_fb(lpfb_q), .done(red_done), .filtered(red_y), .square_sum(red_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= DC_ALPHA_RST; lpin_q <= LP_IN_RST; lpfb_q <= LP_FB_RST;
			winlen_q <= WIN_LEN_RST;
			wcnt_q <= '0; pos_q <= '0; fill_q <= '0;
			busy_q <= 1'b0; start_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			start_q <= in_valid && in_ready;
			if (cfg_we) begin
				case (cfg_index)
					REG_DC_ALPHA: alpha_q  <= cfg_data;
					REG_LP_IN:    lpin_q   <= cfg_data;
					REG_LP_FB:    lpfb_q   <= cfg_data;
					REG_WIN_LEN:  winlen_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (in_valid && in_ready) busy_q <= 1'b1;
			// merge: both lanes finish together
			if (ir_done && red_done) begin
				busy_q    <= 1'b0;
				out_valid <= 1'b1;
				fill_q    <= fill_n;
				pos_q     <= (pos_q == 6'(MEAN_TAPS - 1)) ? '0 : pos_q + 6'd1;
				wcnt_q    <= close ? '0 : wcnt_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ir_q  <= ir_sample;
			red_q <= red_sample;
		end
		if (ir_done && red_done) begin
			ir_filtered    <= ir_y;
			red_filtered   <= red_y;
			window_done    <= close;
			ir_square_sum  <= close ? ir_sq : '0;
			red_square_sum <= close ? red_sq : '0;
		end
	end
endmodule

// ===== design/pofc_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on pofc_pkg.
module pofc_div import pofc_pkg::*; #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q, quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q, busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	always_comb begin
		trial = {rem_q, mag_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			// remainder stays below den, so it fits DEN_W bits
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ===== design/pofc_lane.sv =====
// One channel of the filter chain: DC removal, mean difference, low-pass, squares.
// Depends on pofc_pkg and pofc_div.
module pofc_lane import pofc_pkg::*; #(
	parameter int MEAN_TAPS = MEAN_TAPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctl_t           ctl,
	input  logic [15:0]         sample,
	input  logic [15:0]         dc_alpha,
	input  logic [15:0]         lp_in,
	input  logic [15:0]         lp_fb,
	output logic                done,
	output logic signed [26:0]  filtered,
	output logic [47:0]         square_sum
);
	localparam int TOT_W = 36 + $clog2(MEAN_TAPS) + 1;
	localparam int POS_W = $clog2(MEAN_TAPS);

	lane_state_t state_q, state_d;

	logic [39:0]        dc_q, dcprev_q;
	logic signed [35:0] ring_q [MEAN_TAPS];
	logic signed [TOT_W-1:0] tot_q;
	logic signed [35:0] lp_q, d_q, m_q, vnew_q;
	logic [55:0]        prod_q;
	logic signed [53:0] pa_q, pb_q;
	logic signed [26:0] y_q;
	logic [47:0]        sq_q;
	logic signed [TOT_W-1:0] avg;
	logic               div_done;
	logic [POS_W-1:0]   pos;
	logic [41:0]        wsum;
	logic signed [53:0] psum;
	logic signed [36:0] ysum;
	logic [53:0]        ysq;
	logic [48:0]        sqsum;

	assign pos = ctl.pos[POS_W-1:0];

	// divider starts once the mean total holds this item's difference
	pofc_div #(.NUM_W(TOT_W), .DEN_W(7)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIV_GO),
		.num(tot_q), .den(ctl.fill), .done(div_done), .quot(avg)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (ctl.start) state_d = ST_DC_MUL;
			ST_DC_MUL:   state_d = ST_DC_SUB;
			ST_DC_SUB:   state_d = ST_MEAN;
			ST_MEAN:     state_d = ST_TOT;
			ST_TOT:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV;
			ST_DIV:      if (div_done) state_d = ST_DIFF;
			ST_DIFF:     state_d = ST_LP_MUL_A;
			ST_LP_MUL_A: state_d = ST_LP_MUL_B;
			ST_LP_MUL_B: state_d = ST_LP_SUM;
			ST_LP_SUM:   state_d = ST_OUT;
			ST_OUT:      state_d = ST_SQ;
			ST_SQ:       state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	assign wsum  = {2'b00, sample, 24'd0} >> 8;  // x<<16 in 42 bits
	assign psum  = pa_q + pb_q;
	assign ysum  = 37'(lp_q) + 37'(vnew_q);
	assign ysq   = 54'($signed(y_q) * $signed(y_q));
	assign sqsum = {1'b0, sq_q} + 49'(ysq[53:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dc_q    <= '0;
			tot_q   <= '0;
			lp_q    <= '0;
			sq_q    <= '0;
			for (int i = 0; i < MEAN_TAPS; i++) ring_q[i] <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_DC_SUB: begin
					if (wsum + 42'(prod_q[55:16]) > 42'hFF_FFFF_FFFF)
						dc_q <= 40'hFF_FFFF_FFFF;
					else
						dc_q <= 40'(wsum + 42'(prod_q[55:16]));
				end
				ST_TOT: begin
					tot_q     <= tot_q + TOT_W'(d_q) - TOT_W'(ring_q[pos]);
					ring_q[pos] <= d_q;
				end
				// y at this edge still sees the previous low-pass value
				ST_OUT: lp_q <= vnew_q;
				ST_SQ: sq_q <= sqsum[48] ? 48'hFFFF_FFFF_FFFF : sqsum[47:0];
				ST_DONE: if (ctl.clear_sq) sq_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_DC_MUL: begin
				prod_q   <= 56'(dc_alpha * dc_q);
				dcprev_q <= dc_q;
			end
			ST_MEAN:     d_q <= sat36(64'(dc_q) - 64'(dcprev_q));
			ST_DIFF:     m_q <= sat36(64'(avg) - 64'(d_q));
			ST_LP_MUL_A: pa_q <= $signed({1'b0, lp_in}) * m_q;
			ST_LP_MUL_B: pb_q <= $signed({1'b0, lp_fb}) * lp_q;
			ST_OUT:      y_q <= sat27(64'(ysum >>> 8));
			default: ;
		endcase
		if (state_q == ST_LP_SUM) vnew_q <= sat36(64'(psum >>> 16));
	end

	assign done       = (state_q == ST_DONE);
	assign filtered   = y_q;
	assign square_sum = sq_q;
endmodule

// ===== dv/pulse_oximeter_filter_chain_top_tb.sv =====
// Testbench for pulse_oximeter_filter_chain_top: directed table, then random sample streams.
// The expected results come from a bit-accurate filter-chain predictor. Depends on pofc_pkg.
`timescale 1ns / 100ps

module pulse_oximeter_filter_chain_top_tb;
	import pofc_pkg::*;

	localparam int  TAPS       = MEAN_TAPS_DEF;
	localparam longint DC_MAX  = 64'hFF_FFFF_FFFF;
	localparam longint SQ_MAX  = 64'hFFFF_FFFF_FFFF;
	localparam int  LIMIT      = 3000000;
	localparam int  DRAIN_WAIT = 200;   // comfortably above the item latency
	localparam int  NPHASE     = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [15:0]           ir_sample;
	logic [15:0]           red_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [26:0]    ir_filtered;
	logic signed [26:0]    red_filtered;
	logic                  window_done;
	logic [47:0]           ir_square_sum;
	logic [47:0]           red_square_sum;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pulse_oximeter_filter_chain_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.ir_sample(ir_sample), .red_sample(red_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.ir_filtered(ir_filtered), .red_filtered(red_filtered),
		.window_done(window_done),
		.ir_square_sum(ir_square_sum), .red_square_sum(red_square_sum),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// one expected output item
	typedef struct {
		logic [26:0] ir_f;
		logic [26:0] red_f;
		logic        done;
		logic [47:0] ir_sq;
		logic [47:0] red_sq;
	} filt_result_t;

	filt_result_t pending_results[$];
	int           error_count;
	int           cycle_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_req;       // set by the stimulus, consumed by the receiver

	// predictor copy of the configuration
	longint alpha_q, lp_in_q, lp_fb_q, win_len_q;
	// predictor copy of the per-channel state; index 0 infrared, 1 red
	longint dc_w[2];
	longint ring_val[2][TAPS];
	longint ring_sum[2];
	longint lp_v[2];
	longint sq_acc[2];
	int     ring_pos, ring_fill, win_cnt;

	// directed stimulus: samples, plus a typed expectation where it is obvious
	typedef struct {
		logic [15:0] ir;
		logic [15:0] red;
		bit          typed;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{16'h0000, 16'h0000, 1'b1},   // zero input from reset state: all zero out
		'{16'h0000, 16'h0000, 1'b1},
		'{16'hFFFF, 16'hFFFF, 1'b0},   // full-scale step
		'{16'hFFFF, 16'h0000, 1'b0},
		'{16'h0000, 16'hFFFF, 1'b0},
		'{16'hFFFF, 16'hFFFF, 1'b0},
		'{16'hFFFF, 16'hFFFF, 1'b0},
		'{16'hFFFF, 16'hFFFF, 1'b0},
		'{16'h5555, 16'hAAAA, 1'b0},
		'{16'hAAAA, 16'h5555, 1'b0},
		'{16'h8000, 16'h7FFF, 1'b0},
		'{16'h0001, 16'hFFFE, 1'b0},
		'{16'h0000, 16'h0000, 1'b0},   // drop back to zero while the ring is still filling
		'{16'h0000, 16'h0000, 1'b0},
		'{16'h1234, 16'h0FED, 1'b0},
		'{16'hFFFF, 16'hFFFF, 1'b0},
		'{16'h0000, 16'hFFFF, 1'b0},
		'{16'h7FFF, 16'h8000, 1'b0}
	};

	function automatic longint clamp_s(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// one channel through DC removal, mean difference, low-pass and squaring
	function automatic longint chain_step(int c, longint x, int fill);
		longint prev, w, d, avg, m, vn, y;
		prev = dc_w[c];
		w = (x <<< 16) + ((alpha_q * prev) >>> 16);
		if (w > DC_MAX) w = DC_MAX;
		dc_w[c] = w;
		d = clamp_s(w - prev, 36);
		ring_sum[c] += d - ring_val[c][ring_pos];
		ring_val[c][ring_pos] = d;
		avg = ring_sum[c] / fill;               // truncates toward zero
		m = clamp_s(avg - d, 36);
		vn = clamp_s((lp_in_q * m + lp_fb_q * lp_v[c]) >>> 16, 36);
		y = clamp_s((lp_v[c] + vn) >>> 8, 27);
		lp_v[c] = vn;
		sq_acc[c] += (y * y) >>> 16;
		if (sq_acc[c] > SQ_MAX) sq_acc[c] = SQ_MAX;
		return y;
	endfunction

	function automatic filt_result_t predict_filter(logic [15:0] ir, logic [15:0] red);
		filt_result_t r;
		int fill;
		longint yi, yr;
		fill = (ring_fill < TAPS) ? ring_fill + 1 : TAPS;
		yi = chain_step(0, longint'(ir), fill);
		yr = chain_step(1, longint'(red), fill);
		ring_pos = (ring_pos + 1) % TAPS;
		ring_fill = fill;
		r.ir_f = yi[26:0];
		r.red_f = yr[26:0];
		// zero length behaves as one; shortening closes on the next sample
		if (longint'(win_cnt) + 1 >= win_len_q) begin
			r.done = 1'b1;
			r.ir_sq = sq_acc[0][47:0];
			r.red_sq = sq_acc[1][47:0];
			sq_acc[0] = 0;
			sq_acc[1] = 0;
			win_cnt = 0;
		end else begin
			r.done = 1'b0;
			r.ir_sq = '0;
			r.red_sq = '0;
			win_cnt = (win_cnt + 1) & 10'h3FF;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("FAIL pulse_oximeter_filter_chain_top");
			$finish;
		end
	end

	// receiver: check accepted items, then decide ready for the next edge
	int hold_left;
	always @(posedge clk) begin
		filt_result_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected output item", 1, 0);
			end else begin
				e = pending_results.pop_front();
				if (ir_filtered !== e.ir_f)
					report_mismatch("ir_filtered", ir_filtered, e.ir_f);
				if (red_filtered !== e.red_f)
					report_mismatch("red_filtered", red_filtered, e.red_f);
				if (window_done !== e.done)
					report_mismatch("window_done", window_done, e.done);
				if (ir_square_sum !== e.ir_sq)
					report_mismatch("ir_square_sum", ir_square_sum, e.ir_sq);
				if (red_square_sum !== e.red_sq)
					report_mismatch("red_square_sum", red_square_sum, e.red_sq);
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// offer one item, with random idle cycles first; returns at acceptance
	task automatic send_item(logic [15:0] ir, logic [15:0] red, bit typed);
		filt_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ir_sample <= ir;
		red_sample <= red;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_filter(ir, red);
		if (typed) begin
			r.ir_f = '0;
			r.red_f = '0;
			r.done = 1'b0;
			r.ir_sq = '0;
			r.red_sq = '0;
		end
		pending_results.push_back(r);
	endtask

	// drop valid right after the last acceptance, let every expected item drain
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DC_ALPHA: alpha_q = val;
			REG_LP_IN:    lp_in_q = val;
			REG_LP_FB:    lp_fb_q = val;
			REG_WIN_LEN:  win_len_q = val[9:0];
			default: ;
		endcase
	endtask

	initial begin
		logic [15:0] cur_ir, cur_red, nir, nred;
		logic [15:0] ca, ci, cf, cw;
		int kind;
		int n_items;

		arst_n = 1'b0;
		in_valid = 1'b0;
		ir_sample = '0;
		red_sample = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		hold_left = 0;

		alpha_q = DC_ALPHA_RST;
		lp_in_q = LP_IN_RST;
		lp_fb_q = LP_FB_RST;
		win_len_q = WIN_LEN_RST;
		for (int c = 0; c < 2; c++) begin
			dc_w[c] = 0;
			ring_sum[c] = 0;
			lp_v[c] = 0;
			sq_acc[c] = 0;
			for (int t = 0; t < TAPS; t++) ring_val[c][t] = 0;
		end
		ring_pos = 0;
		ring_fill = 0;
		win_cnt = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings, no idling
		foreach (dir_rows[i])
			send_item(dir_rows[i].ir, dir_rows[i].red, dir_rows[i].typed);

		cur_ir = 16'h8000;
		cur_red = 16'h6000;
		for (int p = 0; p < NPHASE; p++) begin
			if (p > 0) begin
				wait_drained();
				case (p)
					1: begin ca = '0; ci = '0; cf = '0; cw = 16'hFC00; end
					2: begin ca = 16'hFFFF; ci = 16'hFFFF; cf = 16'hFFFF; cw = 16'd1023; end
					3: begin ca = DC_ALPHA_RST; ci = LP_IN_RST; cf = LP_FB_RST; cw = 16'd7; end
					4: begin ca = 16'hFFFF; ci = 16'h8000; cf = 16'h7FFF; cw = 16'd1; end
					default: begin
						ca = 16'($urandom);
						ci = 16'($urandom);
						cf = 16'($urandom);
						cw = 16'(($urandom_range(0, 3) == 0) ? $urandom
							: $urandom_range(1, 40));
					end
				endcase
				// phase 3 shortens the window below the count left by phase 2
				write_reg(REG_DC_ALPHA, ca);
				write_reg(REG_LP_IN, ci);
				write_reg(REG_LP_FB, cf);
				write_reg(REG_WIN_LEN, cw);
			end
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			n_items = (p == 0) ? 60 : 165;
			for (int k = 0; k < n_items; k++) begin
				// long receiver hold-off while the sender keeps offering
				if (p == 4 && k == 20) hold_req = 2500;
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					// slowly varying waveform, the usual sensor shape
					nir = cur_ir + 16'($signed($urandom_range(0, 512)) - 256);
					nred = cur_red + 16'($signed($urandom_range(0, 512)) - 256);
				end else if (kind < 8) begin
					nir = 16'($urandom);
					nred = 16'($urandom);
				end else begin
					nir = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					nred = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				end
				cur_ir = nir;
				cur_red = nred;
				send_item(nir, nred, 1'b0);
			end
		end

		wait_drained();
		if (error_count == 0)
			$display("PASS pulse_oximeter_filter_chain_top");
		else
			$display("FAIL pulse_oximeter_filter_chain_top");
		$finish;
	end

endmodule

// ===== files.f =====
design/pofc_pkg.sv
design/pofc_div.sv
design/pofc_lane.sv
design/pulse_oximeter_filter_chain_top.sv
dv/pulse_oximeter_filter_chain_top_tb.sv
